// ===== rtl/psgl_pkg.sv =====
// Package for the profile smoothing and grade limiting unit.
// Holds field types, fixed widths, controller states and the command/status bundles.
// No dependencies.
package psgl_pkg;

  localparam int HEIGHT_W = 32;
  localparam int POS_W    = 32;
  localparam int GRADE_W  = 20;
  localparam int PROD_W   = GRADE_W + POS_W;
  localparam int LIM_W    = PROD_W - 16;
  localparam int CMP_W    = LIM_W + 2;

  localparam logic [GRADE_W-1:0] GRADE_RESET = 20'd6554;
  localparam int MIN_SAMPLES = 3;

  typedef logic signed [HEIGHT_W-1:0] height_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [GRADE_W-1:0]         grade_t;
  typedef logic [LIM_W-1:0]           lim_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SM_RD0,
    ST_SM_RD1,
    ST_SM_LD,
    ST_SM_RD,
    ST_SM_WR,
    ST_CL_RD0,
    ST_CL_REF,
    ST_CL_RD,
    ST_CL_SP,
    ST_CL_MUL,
    ST_CL_WR,
    ST_CL_END,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_WAIT
  } state_t;

  typedef struct packed {
    logic ld_wr;
    logic sm_wr;
    logic cl_wr;
    logic ld_prev;
    logic ld_cur;
    logic ld_ref;
    logic ld_sp;
    logic backward;
    logic ld_lim;
    logic clr_changed;
    logic out_load;
    logic out_eop;
    logic out_ovf;
  } cmd_t;

  typedef struct packed {
    logic grade_zero;
    logic changed;
    logic out_taken;
  } stat_t;

endpackage

// ===== rtl/psgl_ctrl.sv =====
// Controller for the profile unit: load, smoothing, clamp sweeps and emission sequencing.
// Owns sample count, drop flag and loop counters; drives the datapath through psgl_pkg::cmd_t.
// Depends on psgl_pkg.
module psgl_ctrl #(
  parameter int MAX_SAMPLES   = 64,
  parameter int MAX_ROUNDS    = 128,
  parameter int SMOOTH_PASSES = 2,
  parameter int AW            = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_stall,
  input  psgl_pkg::stat_t stat,
  output psgl_pkg::cmd_t  cmd,
  output logic [AW-1:0]   addr
);

  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int PSW = $clog2(SMOOTH_PASSES + 2);
  localparam int RW  = $clog2(MAX_ROUNDS + 1);

  psgl_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           dropped_r, dropped_nxt;
  logic [PSW-1:0] pass_r, pass_nxt;
  logic [RW-1:0]  round_r, round_nxt;
  logic           dir_r, dir_nxt;

  logic          in_acc;
  logic          has_room;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] count_m2;
  logic [CW-1:0] idx_p1;

  assign in_acc   = in_valid && (state_r == psgl_pkg::ST_LOAD);
  assign has_room = count_r < CW'(MAX_SAMPLES);
  assign count_m1 = count_r - CW'(1);
  assign count_m2 = count_r - CW'(2);
  assign idx_p1   = idx_r + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= psgl_pkg::ST_LOAD;
      idx_r     <= '0;
      count_r   <= '0;
      dropped_r <= 1'b0;
      pass_r    <= '0;
      round_r   <= '0;
      dir_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      pass_r    <= pass_nxt;
      round_r   <= round_nxt;
      dir_r     <= dir_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    pass_nxt    = pass_r;
    round_nxt   = round_r;
    dir_nxt     = dir_r;
    unique case (state_r)
      psgl_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = psgl_pkg::ST_CHECK;
          end
        end
      end
      psgl_pkg::ST_CHECK: begin
        idx_nxt = '0;
        if (count_r < CW'(psgl_pkg::MIN_SAMPLES) || stat.grade_zero) begin
          state_nxt = psgl_pkg::ST_EM_RD;
        end else if (SMOOTH_PASSES > 0) begin
          pass_nxt  = '0;
          state_nxt = psgl_pkg::ST_SM_RD0;
        end else begin
          state_nxt = psgl_pkg::ST_CL_RD0;
        end
      end
      psgl_pkg::ST_SM_RD0: state_nxt = psgl_pkg::ST_SM_RD1;
      psgl_pkg::ST_SM_RD1: state_nxt = psgl_pkg::ST_SM_LD;
      psgl_pkg::ST_SM_LD: begin
        idx_nxt   = CW'(1);
        state_nxt = psgl_pkg::ST_SM_RD;
      end
      psgl_pkg::ST_SM_RD: state_nxt = psgl_pkg::ST_SM_WR;
      psgl_pkg::ST_SM_WR: begin
        if (idx_r == count_m2) begin
          if (pass_r == PSW'(SMOOTH_PASSES - 1)) begin
            state_nxt = psgl_pkg::ST_CL_RD0;
          end else begin
            pass_nxt  = pass_r + PSW'(1);
            state_nxt = psgl_pkg::ST_SM_RD0;
          end
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = psgl_pkg::ST_SM_RD;
        end
      end
      psgl_pkg::ST_CL_RD0: begin
        round_nxt = '0;
        dir_nxt   = 1'b0;
        state_nxt = psgl_pkg::ST_CL_REF;
      end
      psgl_pkg::ST_CL_REF: begin
        idx_nxt   = CW'(1);
        state_nxt = psgl_pkg::ST_CL_RD;
      end
      psgl_pkg::ST_CL_RD:  state_nxt = psgl_pkg::ST_CL_SP;
      psgl_pkg::ST_CL_SP:  state_nxt = psgl_pkg::ST_CL_MUL;
      psgl_pkg::ST_CL_MUL: state_nxt = psgl_pkg::ST_CL_WR;
      psgl_pkg::ST_CL_WR: begin
        if (!dir_r) begin
          if (idx_r == count_m1) begin
            dir_nxt = 1'b1;
            idx_nxt = count_m2;
          end else begin
            idx_nxt = idx_p1;
          end
          state_nxt = psgl_pkg::ST_CL_RD;
        end else if (idx_r == '0) begin
          state_nxt = psgl_pkg::ST_CL_END;
        end else begin
          idx_nxt   = idx_r - CW'(1);
          state_nxt = psgl_pkg::ST_CL_RD;
        end
      end
      psgl_pkg::ST_CL_END: begin
        if (!stat.changed || round_r == RW'(MAX_ROUNDS - 1)) begin
          idx_nxt   = '0;
          state_nxt = psgl_pkg::ST_EM_RD;
        end else begin
          round_nxt = round_r + RW'(1);
          dir_nxt   = 1'b0;
          idx_nxt   = CW'(1);
          state_nxt = psgl_pkg::ST_CL_RD;
        end
      end
      psgl_pkg::ST_EM_RD: state_nxt = psgl_pkg::ST_EM_LD;
      psgl_pkg::ST_EM_LD: state_nxt = psgl_pkg::ST_EM_WAIT;
      psgl_pkg::ST_EM_WAIT: begin
        if (stat.out_taken) begin
          if (idx_r == count_m1) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = psgl_pkg::ST_LOAD;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = psgl_pkg::ST_EM_RD;
          end
        end
      end
      default: state_nxt = psgl_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.backward = dir_r;
    addr         = idx_r[AW-1:0];
    in_stall     = (state_r != psgl_pkg::ST_LOAD);
    unique case (state_r)
      psgl_pkg::ST_LOAD: begin
        addr       = count_r[AW-1:0];
        cmd.ld_wr  = in_acc && has_room;
      end
      psgl_pkg::ST_SM_RD0: addr = '0;
      psgl_pkg::ST_SM_RD1: begin
        addr        = AW'(1);
        cmd.ld_prev = 1'b1;
      end
      psgl_pkg::ST_SM_LD:  cmd.ld_cur = 1'b1;
      psgl_pkg::ST_SM_RD:  addr = idx_p1[AW-1:0];
      psgl_pkg::ST_SM_WR:  cmd.sm_wr = 1'b1;
      psgl_pkg::ST_CL_RD0: begin
        addr            = '0;
        cmd.clr_changed = 1'b1;
      end
      psgl_pkg::ST_CL_REF: cmd.ld_ref = 1'b1;
      psgl_pkg::ST_CL_SP:  cmd.ld_sp = 1'b1;
      psgl_pkg::ST_CL_MUL: cmd.ld_lim = 1'b1;
      psgl_pkg::ST_CL_WR:  cmd.cl_wr = 1'b1;
      psgl_pkg::ST_CL_END: cmd.clr_changed = 1'b1;
      psgl_pkg::ST_EM_LD: begin
        cmd.out_load = 1'b1;
        cmd.out_eop  = (idx_r == count_m1);
        cmd.out_ovf  = dropped_r;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/psgl_dp.sv =====
// Datapath for the profile unit: sample stores, smoothing window, grade limit multiply,
// clamp compare, grade register and the result register.
// Depends on psgl_pkg; driven by psgl_ctrl.
module psgl_dp #(
  parameter int MAX_SAMPLES = 64,
  parameter int AW          = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  psgl_pkg::cmd_t          cmd,
  input  logic [AW-1:0]           addr,
  output psgl_pkg::stat_t         stat,
  input  psgl_pkg::height_t       in_ground_height,
  input  psgl_pkg::pos_t          in_arc_position,
  input  logic                    cfg_valid,
  input  psgl_pkg::grade_t        cfg_max_grade,
  output logic                    out_valid,
  input  logic                    out_stall,
  output psgl_pkg::height_t       out_profile_height,
  output logic                    out_end_of_profile,
  output logic                    out_overflow
);

  psgl_pkg::height_t h_mem   [MAX_SAMPLES];
  psgl_pkg::pos_t    pos_mem [MAX_SAMPLES];

  psgl_pkg::height_t rd_h_r;
  psgl_pkg::pos_t    rd_pos_r;
  psgl_pkg::height_t prev_r, cur_r;
  psgl_pkg::height_t ref_h_r;
  psgl_pkg::pos_t    ref_pos_r, cur_pos_r;
  psgl_pkg::pos_t    sp_r;
  psgl_pkg::lim_t    lim_r;
  psgl_pkg::grade_t  grade_r;
  logic              changed_r;
  logic              out_valid_r;
  psgl_pkg::height_t out_h_r;
  logic              out_eop_r, out_ovf_r;

  logic signed [psgl_pkg::HEIGHT_W+1:0] sm_sum;
  psgl_pkg::height_t                    sm_val;
  logic [psgl_pkg::POS_W:0]             sp_diff;
  psgl_pkg::pos_t                       sp_val;
  logic [psgl_pkg::PROD_W-1:0]          prod;
  logic signed [psgl_pkg::CMP_W-1:0]    ref_ext, cur_ext, lim_ext, hi, lo;
  psgl_pkg::height_t                    cl_val;
  logic                                 cl_hit;

  assign sm_sum = {{2{prev_r[psgl_pkg::HEIGHT_W-1]}}, prev_r}
                + {cur_r[psgl_pkg::HEIGHT_W-1], cur_r, 1'b0}
                + {{2{rd_h_r[psgl_pkg::HEIGHT_W-1]}}, rd_h_r};
  assign sm_val = sm_sum[psgl_pkg::HEIGHT_W+1:2];

  always_comb begin
    if (cmd.backward) begin
      sp_diff = {1'b0, ref_pos_r} - {1'b0, rd_pos_r};
    end else begin
      sp_diff = {1'b0, rd_pos_r} - {1'b0, ref_pos_r};
    end
    if (sp_diff[psgl_pkg::POS_W] || sp_diff == '0) begin
      sp_val = psgl_pkg::POS_W'(1);
    end else begin
      sp_val = sp_diff[psgl_pkg::POS_W-1:0];
    end
  end

  assign prod = psgl_pkg::PROD_W'(grade_r) * psgl_pkg::PROD_W'(sp_r);

  assign ref_ext = psgl_pkg::CMP_W'(ref_h_r);
  assign cur_ext = psgl_pkg::CMP_W'(cur_r);
  assign lim_ext = $signed({2'b00, lim_r});
  assign hi      = ref_ext + lim_ext;
  assign lo      = ref_ext - lim_ext;

  always_comb begin
    priority if (cur_ext > hi) begin
      cl_val = hi[psgl_pkg::HEIGHT_W-1:0];
      cl_hit = 1'b1;
    end else if (cur_ext < lo) begin
      cl_val = lo[psgl_pkg::HEIGHT_W-1:0];
      cl_hit = 1'b1;
    end else begin
      cl_val = cur_r;
      cl_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_wr) begin
      h_mem[addr]   <= in_ground_height;
      pos_mem[addr] <= in_arc_position;
    end else if (cmd.sm_wr) begin
      h_mem[addr] <= sm_val;
    end else if (cmd.cl_wr) begin
      h_mem[addr] <= cl_val;
    end
    rd_h_r   <= h_mem[addr];
    rd_pos_r <= pos_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_prev) begin
      prev_r <= rd_h_r;
    end else if (cmd.sm_wr) begin
      prev_r <= cur_r;
    end
    if (cmd.ld_cur || cmd.sm_wr || cmd.ld_sp) begin
      cur_r <= rd_h_r;
    end
    if (cmd.ld_sp) begin
      sp_r      <= sp_val;
      cur_pos_r <= rd_pos_r;
    end
    if (cmd.ld_lim) begin
      lim_r <= prod[psgl_pkg::PROD_W-1:16];
    end
    if (cmd.ld_ref) begin
      ref_h_r   <= rd_h_r;
      ref_pos_r <= rd_pos_r;
    end else if (cmd.cl_wr) begin
      ref_h_r   <= cl_val;
      ref_pos_r <= cur_pos_r;
    end
    if (cmd.out_load) begin
      out_h_r   <= rd_h_r;
      out_eop_r <= cmd.out_eop;
      out_ovf_r <= cmd.out_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grade_r     <= psgl_pkg::GRADE_RESET;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        grade_r <= cfg_max_grade;
      end
      if (cmd.clr_changed) begin
        changed_r <= 1'b0;
      end else if (cmd.cl_wr && cl_hit) begin
        changed_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.grade_zero = (grade_r == '0);
  assign stat.changed    = changed_r;
  assign stat.out_taken  = out_valid_r && !out_stall;

  assign out_valid          = out_valid_r;
  assign out_profile_height = out_h_r;
  assign out_end_of_profile = out_eop_r;
  assign out_overflow       = out_ovf_r;

endmodule

// ===== rtl/profile_smooth_grade_limit_unit.sv =====
// Top level of the profile smoothing and grade limiting unit.
// Instantiates psgl_ctrl and psgl_dp; depends on psgl_pkg.
//
//   Port group | Handshake           | Carries
//   in_        | in_valid / in_stall | ground_height, arc_position, last
//   out_       | out_valid/out_stall | profile_height, end_of_profile, overflow
//   cfg_       | cfg_valid/cfg_ready | max_grade
//
// Samples load at one request per cycle; the request marked last starts processing.
// A check step skips to emission below MIN_SAMPLES samples or at zero grade; else the
// smoothing passes, the clamp set-up and the clamp rounds run, paced by the store's single read port.
// Each result waits out any out_stall before the next is read; no input is taken
// until the last result is taken. Reset is synchronous; the stores need no clearing.
module profile_smooth_grade_limit_unit #(
  parameter int MAX_SAMPLES   = 64,
  parameter int MAX_ROUNDS    = 128,
  parameter int SMOOTH_PASSES = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  psgl_pkg::height_t       in_ground_height,
  input  psgl_pkg::pos_t          in_arc_position,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output psgl_pkg::height_t       out_profile_height,
  output logic                    out_end_of_profile,
  output logic                    out_overflow,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  psgl_pkg::grade_t        cfg_max_grade
);

  localparam int AW = $clog2(MAX_SAMPLES);

  psgl_pkg::cmd_t  cmd;
  psgl_pkg::stat_t stat;
  logic [AW-1:0]   addr;

  assign cfg_ready = 1'b1;

  psgl_ctrl #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .MAX_ROUNDS   (MAX_ROUNDS),
    .SMOOTH_PASSES(SMOOTH_PASSES),
    .AW           (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_last (in_last),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd),
    .addr    (addr)
  );

  psgl_dp #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .AW         (AW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .addr              (addr),
    .stat              (stat),
    .in_ground_height  (in_ground_height),
    .in_arc_position   (in_arc_position),
    .cfg_valid         (cfg_valid),
    .cfg_max_grade     (cfg_max_grade),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_profile_height(out_profile_height),
    .out_end_of_profile(out_end_of_profile),
    .out_overflow      (out_overflow)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for profile_smooth_grade_limit_unit.
// It predicts each emitted profile (smoothing, grade clamp, overflow) and compares
// every result. Depends on rtl/psgl_pkg.sv and the unit's RTL.
module tb;

  localparam int MAX_N         = 64;
  localparam int MAX_ROUNDS    = 128;
  localparam int SMOOTH_PASSES = 2;
  localparam int RANDOM_ITEMS  = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 12;

  typedef enum int {SHAPE_CLEAN, SHAPE_BROKEN, SHAPE_NOISE} shape_t;

  typedef struct packed {
    psgl_pkg::height_t height;
    logic              eop;
    logic              ovf;
  } point_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  psgl_pkg::height_t in_ground_height = '0;
  psgl_pkg::pos_t    in_arc_position = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  psgl_pkg::height_t out_profile_height;
  logic              out_end_of_profile;
  logic              out_overflow;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  psgl_pkg::grade_t  cfg_max_grade = '0;

  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;
  logic rx_hold = 1'b0;
  event hold_go;
  int   fault_cnt = 0;

  longint           prof_h [MAX_N];
  psgl_pkg::pos_t   prof_p [MAX_N];
  int               prof_n = 0;
  bit               prof_drop = 1'b0;
  psgl_pkg::grade_t grade_q = psgl_pkg::GRADE_RESET;
  point_t           profile_due [$];

  profile_smooth_grade_limit_unit #(
    .MAX_SAMPLES  (MAX_N),
    .MAX_ROUNDS   (MAX_ROUNDS),
    .SMOOTH_PASSES(SMOOTH_PASSES)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ground_height  (in_ground_height),
    .in_arc_position   (in_arc_position),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_profile_height(out_profile_height),
    .out_end_of_profile(out_end_of_profile),
    .out_overflow      (out_overflow),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_grade     (cfg_max_grade)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint step_limit(int a, int b);
    longint sp;
    sp = longint'(prof_p[b]) - longint'(prof_p[a]);
    if (sp < 1) sp = 1;
    return (longint'(grade_q) * sp) >>> 16;
  endfunction

  function automatic bit pull_toward(int dst, int anchor, longint lim);
    longint hi;
    longint lo;
    hi = prof_h[anchor] + lim;
    lo = prof_h[anchor] - lim;
    if (prof_h[dst] > hi) begin
      prof_h[dst] = hi;
      return 1'b1;
    end
    if (prof_h[dst] < lo) begin
      prof_h[dst] = lo;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void smooth_and_limit(int n);
    longint nxt [MAX_N];
    bit     moved;
    if (n < psgl_pkg::MIN_SAMPLES || grade_q == '0) return;
    for (int p = 0; p < SMOOTH_PASSES; p++) begin
      for (int i = 1; i + 1 < n; i++)
        nxt[i] = (prof_h[i-1] + 2 * prof_h[i] + prof_h[i+1]) >>> 2;
      for (int i = 1; i + 1 < n; i++)
        prof_h[i] = nxt[i];
    end
    moved = 1'b1;
    for (int r = 0; r < MAX_ROUNDS && moved; r++) begin
      moved = 1'b0;
      for (int i = 1; i < n; i++)
        if (pull_toward(i, i - 1, step_limit(i - 1, i))) moved = 1'b1;
      for (int i = n - 2; i >= 0; i--)
        if (pull_toward(i, i + 1, step_limit(i, i + 1))) moved = 1'b1;
    end
  endfunction

  function automatic void take_sample(psgl_pkg::height_t h, psgl_pkg::pos_t p, logic l);
    point_t pt;
    if (prof_n < MAX_N) begin
      prof_h[prof_n] = longint'(h);
      prof_p[prof_n] = p;
      prof_n++;
    end else begin
      prof_drop = 1'b1;
    end
    if (l) begin
      smooth_and_limit(prof_n);
      for (int k = 0; k < prof_n; k++) begin
        pt.height = psgl_pkg::height_t'(prof_h[k][31:0]);
        pt.eop    = (k == prof_n - 1);
        pt.ovf    = prof_drop;
        profile_due.insert(profile_due.size(), pt);
      end
      prof_n    = 0;
      prof_drop = 1'b0;
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    fault_cnt++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  task automatic check_result();
    point_t want;
    if (profile_due.size() == 0) begin
      flag_mismatch("result with none pending", out_profile_height, '0);
    end else begin
      want = profile_due.pop_front();
      if (out_profile_height !== want.height)
        flag_mismatch("profile_height", out_profile_height, want.height);
      if (out_end_of_profile !== want.eop)
        flag_mismatch("end_of_profile", 32'(out_end_of_profile), 32'(want.eop));
      if (out_overflow !== want.ovf)
        flag_mismatch("overflow", 32'(out_overflow), 32'(want.ovf));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) grade_q = cfg_max_grade;
      if (in_valid && !in_stall) take_sample(in_ground_height, in_arc_position, in_last);
    end
  end

  always @(posedge clk)
    out_stall <= rx_hold || (rx_idle && $urandom_range(99) < 16);

  // hold the receiver off for a counted stretch
  initial begin
    forever begin
      @(hold_go);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  task automatic send_sample(input psgl_pkg::height_t h, input psgl_pkg::pos_t p,
                             input logic l);
    while (tx_idle && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_ground_height <= h;
    in_arc_position  <= p;
    in_last          <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (profile_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_grade(input psgl_pkg::grade_t g);
    drain();
    cfg_valid     <= 1'b1;
    cfg_max_grade <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_profile(input int len, input shape_t shape);
    psgl_pkg::height_t h;
    psgl_pkg::pos_t    p;
    int                delta;
    h = $urandom;
    p = (shape == SHAPE_NOISE) ? $urandom : $urandom_range(32'h4000_0000);
    for (int k = 0; k < len; k++) begin
      if (shape == SHAPE_NOISE) begin
        h = $urandom;
        p = $urandom;
      end else begin
        delta = int'($urandom_range(32'h8_0000)) - 32'h4_0000;
        h = ($urandom_range(9) == 0) ? psgl_pkg::height_t'($urandom) : h + delta;
        if (shape == SHAPE_CLEAN || $urandom_range(1) == 1)
          p = p + $urandom_range(32'h4_0000);
        else
          p = p - $urandom_range(32'h2_0000);
      end
      send_sample(h, p, k == len - 1);
    end
  endtask

  task automatic test_extremes();
    send_sample(32'sh7fff_ffff, 32'h0000_0000, 1'b0);
    send_sample(32'sh8000_0000, 32'h0001_0000, 1'b0);
    send_sample(32'sh0000_0000, 32'h0001_0000, 1'b0);
    send_sample(32'shffff_ffff, 32'h0000_8000, 1'b0);
    send_sample(32'sh7fff_ffff, 32'hffff_ffff, 1'b0);
    send_sample(32'sh8000_0000, 32'hffff_ffff, 1'b1);
  endtask

  task automatic test_short_profiles();
    send_sample(32'sh1234_5678, 32'h0000_0100, 1'b1);
    send_sample(32'sh7fff_ffff, 32'h0000_0000, 1'b0);
    send_sample(32'sh8000_0000, 32'h0000_0001, 1'b1);
    send_sample(32'sh0010_0000, 32'h0000_0000, 1'b0);
    send_sample(32'shfff0_0000, 32'h0001_0000, 1'b0);
    send_sample(32'sh0020_0000, 32'h0002_0000, 1'b1);
  endtask

  task automatic test_grade_ends();
    write_grade('0);
    send_sample(32'sh0100_0000, 32'h0000_0000, 1'b0);
    send_sample(32'shff00_0000, 32'h0001_0000, 1'b0);
    send_sample(32'sh0100_0000, 32'h0002_0000, 1'b0);
    send_sample(32'sh8000_0000, 32'h0003_0000, 1'b1);
    write_grade('1);
    send_sample(32'sh0000_0000, 32'h0000_0000, 1'b0);
    send_sample(32'sh4000_0000, 32'h0000_0001, 1'b0);
    send_sample(32'shc000_0000, 32'h0100_0000, 1'b0);
    send_sample(32'sh7fff_ffff, 32'h0100_0000, 1'b1);
    write_grade(20'd1);
    send_sample(32'sh0000_0000, 32'h0000_0000, 1'b0);
    send_sample(32'sh0800_0000, 32'h0000_0001, 1'b0);
    send_sample(32'shf800_0000, 32'h0000_0000, 1'b1);
  endtask

  task automatic test_overflow();
    write_grade(20'h0_2000);
    send_profile(MAX_N + 1, SHAPE_CLEAN);
    send_profile(MAX_N + 3, SHAPE_NOISE);
    send_profile(MAX_N, SHAPE_BROKEN);
  endtask

  task automatic test_backpressure();
    write_grade(psgl_pkg::GRADE_RESET);
    -> hold_go;
    send_profile(12, SHAPE_CLEAN);
    send_profile(12, SHAPE_CLEAN);
  endtask

  task automatic test_random();
    int               sent;
    int               profiles;
    int               len;
    int               pick;
    psgl_pkg::grade_t g;
    shape_t           shape;
    sent     = 0;
    profiles = 0;
    while (sent < RANDOM_ITEMS) begin
      if (profiles % 6 == 0) begin
        case ($urandom_range(15))
          0:       g = '0;
          1:       g = 20'd1;
          2:       g = '1;
          3:       g = psgl_pkg::GRADE_RESET;
          4, 5, 6: g = psgl_pkg::grade_t'($urandom_range(16'hffff));
          default: g = psgl_pkg::grade_t'($urandom);
        endcase
        write_grade(g);
      end
      tx_idle = !(sent > 20 && sent < 80);
      rx_idle = tx_idle;
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(10, 1);
      else if (pick < 95) len = $urandom_range(24, 11);
      else len = $urandom_range(MAX_N, 25);
      pick = $urandom_range(99);
      if (pick < 75) shape = SHAPE_CLEAN;
      else if (pick < 88) shape = SHAPE_BROKEN;
      else shape = SHAPE_NOISE;
      send_profile(len, shape);
      sent += len;
      profiles++;
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_short_profiles();
    test_grade_ends();
    test_overflow();
    test_backpressure();
    test_random();
    drain();
    if (fault_cnt == 0)
      $display("[profile_smooth_grade_limit_unit] OK");
    else
      $display("[profile_smooth_grade_limit_unit] ERROR");
    $finish;
  end

  initial begin
    #16_000_000;
    $display("[profile_smooth_grade_limit_unit] ERROR");
    $finish;
  end

endmodule

// ===== profile_smooth_grade_limit_unit.f =====
rtl/psgl_pkg.sv
rtl/psgl_ctrl.sv
rtl/psgl_dp.sv
rtl/profile_smooth_grade_limit_unit.sv
dv/tb.sv
